[src/sssd_pkg.sv]
// Shared types, constants and the segment table for the serial display writer.
package sssd_pkg;

   // Command bytes of the three transfers
   localparam logic [7:0] CMD_DATA = 8'h40;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [7:0] CMD_CTRL = 8'h88;

   localparam int unsigned DIGITS      = 4;
   localparam int unsigned VALUE_W     = 16;
   localparam int unsigned TICK_W      = 5;
   localparam logic [4:0]  TICK_LAST   = 5'd17;  // ack clock high phase
   localparam logic [4:0]  FRAME_LAST  = 5'd1;   // second tick of start / stop
   localparam logic [2:0]  ADDR_LAST   = 3'd4;   // address byte plus four digits
   localparam logic [1:0]  DIV_LAST    = 2'd3;   // four divide-by-ten steps
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;  // 2^19 / 10, rounded up

   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_BYTES = 3'b010,
      PH_STOP  = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      FRAME_CMD  = 3'b001,
      FRAME_ADDR = 3'b010,
      FRAME_CTRL = 3'b100
   } frame_type;

   // Converter to sequencer
   typedef struct packed {
      logic             wr;
      logic             run;
      logic [3:0][3:0]  digits;   // [3] thousands ... [0] ones
   } bcd_res_type;

   // Sequencer status and pin levels for one item
   typedef struct packed {
      logic clock_line;
      logic data_line;
      logic busy;
      logic done;
      logic seg_rd;
      logic bcd_load;
   } seq_out_type;

   function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0: pat = 7'h3F;
         4'd1: pat = 7'h06;
         4'd2: pat = 7'h5B;
         4'd3: pat = 7'h4F;
         4'd4: pat = 7'h66;
         4'd5: pat = 7'h6D;
         4'd6: pat = 7'h7D;
         4'd7: pat = 7'h07;
         4'd8: pat = 7'h7F;
         4'd9: pat = 7'h6F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

[src/sssd_if.sv]
// Valid/ready channel interfaces for request and response items.
interface sssd_req_if;
   logic        valid;
   logic        ready;
   logic        start_request;
   logic [15:0] display_value;

   modport source (output valid, output start_request, output display_value, input ready);
   modport sink   (input valid, input start_request, input display_value, output ready);
endinterface

interface sssd_rsp_if;
   logic valid;
   logic ready;
   logic clock_line;
   logic data_line;
   logic busy_res;
   logic update_done;

   modport source (output valid, output clock_line, output data_line, output busy_res,
                   output update_done, input ready);
   modport sink   (input valid, input clock_line, input data_line, input busy_res,
                   input update_done, output ready);
endinterface

[src/sssd_bcd.sv]
// Binary to four-digit decimal converter, one reciprocal divide-by-ten step per cycle.
module sssd_bcd
   import sssd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [VALUE_W-1:0] value,
   output bcd_res_type        res
);

   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [3:0][3:0]    bcd_ff, bcd_in;
   logic [1:0]         count_ff, count_in;
   logic               run_ff, run_in;
   logic               wr_ff, wr_in;
   logic [31:0]        prod;
   logic [VALUE_W-4:0] quot;
   logic [VALUE_W-1:0] ten_quot;
   logic [VALUE_W-1:0] diff;

   // x / 10 = (x * 0xCCCD) >> 19, exact over the 16-bit range
   assign prod     = 32'(rem_ff) * 32'(DIV10_MUL);
   assign quot     = prod[31:19];
   assign ten_quot = {quot, 3'b000} + {2'b00, quot, 1'b0};
   assign diff     = rem_ff - ten_quot;

   always_comb begin
      rem_in   = rem_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      run_in   = run_ff;
      wr_in    = 1'b0;
      if (load) begin
         rem_in   = value;
         bcd_in   = '0;
         count_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         // remainder enters at the top; the last one is the thousands digit mod 10
         bcd_in   = {diff[3:0], bcd_ff[3], bcd_ff[2], bcd_ff[1]};
         rem_in   = {3'b000, quot};
         count_in = count_ff + 2'd1;
         if (count_ff == DIV_LAST) begin
            run_in = 1'b0;
            wr_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         wr_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bcd_ff <= bcd_in;
   end

   assign res.wr     = wr_ff;
   assign res.run    = run_ff;
   assign res.digits = bcd_ff;

endmodule

[src/sssd_seq.sv]
// Frame sequencer: tick counters, segment store and pin levels per item.
module sssd_seq
   import sssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        start_request,
   input  logic [2:0]  brightness,
   input  bcd_res_type bcd_res,
   output seq_out_type seq_out
);

   logic               busy_ff, busy_in;
   phase_type          phase_ff, phase_in;
   frame_type          frame_ff, frame_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [2:0]         byte_ff, byte_in;
   logic [6:0]         seg_store_ff [DIGITS];

   logic       starting, active, last_byte, last_tick, done;
   logic [7:0] cur_byte;
   logic [2:0] seg_idx_w;
   logic [1:0] seg_idx;
   logic       clk_lvl, dat_lvl;

   assign starting  = step && !busy_ff && start_request;
   assign active    = busy_ff || starting;
   assign seg_idx_w = byte_ff - 3'd1;
   assign seg_idx   = seg_idx_w[1:0];
   assign last_byte = (frame_ff == FRAME_ADDR) ? (byte_ff == ADDR_LAST) : 1'b1;
   assign last_tick = (phase_ff == PH_BYTES) ? (tick_ff == TICK_LAST)
                                             : (tick_ff == FRAME_LAST);

   always_comb begin
      case (frame_ff)
         FRAME_CMD:  cur_byte = CMD_DATA;
         FRAME_ADDR: cur_byte = (byte_ff == 3'd0) ? CMD_ADDR : {1'b0, seg_store_ff[seg_idx]};
         FRAME_CTRL: cur_byte = CMD_CTRL | {5'd0, brightness};
         default:    cur_byte = CMD_DATA;
      endcase
   end

   // pin levels for the current tick
   always_comb begin
      case (phase_ff)
         PH_START: begin
            clk_lvl = 1'b1;
            dat_lvl = (tick_ff == '0);
         end
         PH_BYTES: begin
            clk_lvl = tick_ff[0];
            dat_lvl = tick_ff[4] ? 1'b1 : cur_byte[tick_ff[3:1]];  // ack: data released
         end
         PH_STOP: begin
            clk_lvl = tick_ff[0];
            dat_lvl = 1'b0;
         end
         default: begin
            clk_lvl = 1'b1;
            dat_lvl = 1'b1;
         end
      endcase
   end

   assign done = active && (phase_ff == PH_STOP) && last_tick && (frame_ff == FRAME_CTRL);

   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      frame_in = frame_ff;
      tick_in  = tick_ff;
      byte_in  = byte_ff;
      if (step && active) begin
         busy_in = 1'b1;
         tick_in = tick_ff + 5'd1;
         if (last_tick) begin
            tick_in = '0;
            case (phase_ff)
               PH_START: begin
                  phase_in = PH_BYTES;
                  byte_in  = '0;
               end
               PH_BYTES: begin
                  if (last_byte) phase_in = PH_STOP;
                  else           byte_in  = byte_ff + 3'd1;
               end
               PH_STOP: begin
                  phase_in = PH_START;
                  case (frame_ff)
                     FRAME_CMD:  frame_in = FRAME_ADDR;
                     FRAME_ADDR: frame_in = FRAME_CTRL;
                     default: begin
                        frame_in = FRAME_CMD;
                        busy_in  = 1'b0;
                     end
                  endcase
               end
               default: phase_in = PH_START;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_START;
         frame_ff <= FRAME_CMD;
         tick_ff  <= '0;
         byte_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         frame_ff <= frame_in;
         tick_ff  <= tick_in;
         byte_ff  <= byte_in;
      end
   end

   // store[0] holds the thousands digit
   always_ff @(posedge clock) begin
      if (bcd_res.wr) begin
         for (int i = 0; i < DIGITS; i++) begin
            seg_store_ff[i] <= seg_pattern(bcd_res.digits[DIGITS-1-i]);
         end
      end
   end

   assign seq_out.clock_line = active ? clk_lvl : 1'b1;
   assign seq_out.data_line  = active ? dat_lvl : 1'b1;
   assign seq_out.busy       = active;
   assign seq_out.done       = done;
   assign seq_out.seg_rd     = active && (frame_ff == FRAME_ADDR) && (phase_ff == PH_BYTES)
                               && (byte_ff != 3'd0);
   assign seq_out.bcd_load   = starting;

endmodule

[src/seven_segment_serial_display_writer_core.sv]
// Top level of the two-wire four-digit seven-segment display writer.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+--------------------------------------------
//  req_chan | in  | valid / ready    | start_request, display_value[15:0]
//  rsp_chan | out | valid / ready    | clock_line, data_line, busy_res, update_done
//  csr_*    | in  | APB, pready = 1  | reg 0 @ 0x0: brightness[2:0], reset 7
//
// One result item per request item, held in the result register; an item is
// taken every cycle while the result side keeps up (req ready = result
// register empty or being drained this cycle).
// An update sequence spans 138 items; the digit conversion runs in the background
// from start and the segment store is written when it ends, well before the
// first segment byte goes out.
// Reset is synchronous; afterwards the sequencer's pin levels idle high and brightness is 7.
// A stall on the result side stalls the request side and the sequencer with it.
module seven_segment_serial_display_writer_core
   import sssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sssd_req_if.sink    req_chan,
   sssd_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic        step;
   logic [2:0]  brightness_ff;
   logic        csr_wr;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_clock_ff, rsp_data_ff, rsp_busy_ff, rsp_done_ff;
   bcd_res_type bcd_res;
   seq_out_type seq_out;

   // ---- config port ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0);
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {29'd0, brightness_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= 3'd7;
      end else if (csr_wr) begin
         brightness_ff <= csr_pwdata[2:0];
      end
   end

   // ---- handshake: one result register decouples the two sides ----
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign step           = req_chan.valid && req_chan.ready;

   // decimal digit converter, loaded on the item that starts an update
   sssd_bcd u_bcd (
      .clock   (clock),
      .reset   (reset),
      .load    (seq_out.bcd_load),
      .value   (req_chan.display_value),
      .res     (bcd_res)
   );

   // frame sequencer; advances once per accepted item
   sssd_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .start_request (req_chan.start_request),
      .brightness    (brightness_ff),
      .bcd_res       (bcd_res),
      .seq_out       (seq_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step)               rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_clock_ff <= seq_out.clock_line;
         rsp_data_ff  <= seq_out.data_line;
         rsp_busy_ff  <= seq_out.busy;
         rsp_done_ff  <= seq_out.done;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.clock_line  = rsp_clock_ff;
   assign rsp_chan.data_line   = rsp_data_ff;
   assign rsp_chan.busy_res    = rsp_busy_ff;
   assign rsp_chan.update_done = rsp_done_ff;

   // ---- checks ----

   // final tick of a sequence is always reported as busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_busy_ff)
      else $error("update_done without busy_res");

   // digits must be settled before any segment byte is driven
   a_seg_ready: assert property (@(posedge clock) disable iff (reset)
      (step && seq_out.seg_rd) |-> !bcd_res.run)
      else $error("segment byte read while conversion still running");

   // a new update never starts while the converter is busy
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      seq_out.bcd_load |-> !bcd_res.run)
      else $error("converter reloaded mid-conversion");

   // after the final tick the sequencer only restarts on a new start
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step && seq_out.done) |=> (seq_out.busy == (step && req_chan.start_request)))
      else $error("sequencer still busy after final tick");

endmodule
